@@ src/xsr_pkg.sv @@
`default_nettype none

package xsr_pkg;

  // State geometry
  localparam int DEPTH  = 16;
  localparam int POS_W  = 4;
  localparam int WORD_W = 64;
  localparam int HALF_W = 32;

  // Recurrence shifts and output multiplier
  localparam int SHIFT_A = 31;
  localparam int SHIFT_B = 11;
  localparam int SHIFT_C = 30;
  localparam logic [WORD_W-1:0] MULT_CONST = 64'h1066_89D4_5497_FDB5;
  localparam logic [HALF_W-1:0] MULT_LO    = MULT_CONST[HALF_W-1:0];
  localparam logic [HALF_W-1:0] MULT_HI    = MULT_CONST[WORD_W-1:HALF_W];

  // Input command codes
  localparam logic CMD_GEN  = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;

  // What an accepted word does on its way to the output
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_HIT,
    KIND_ADV
  } kind_t;

  typedef struct packed {
    kind_t kind;
    word_t word;
  } item_t;

  // State memory write request
  typedef struct packed {
    logic  en;
    pos_t  addr;
    word_t data;
  } ram_wr_t;

  // One step of the xorshift1024 recurrence: s0 = word at position, s1 = following word
  function automatic word_t xsr_next(input word_t s0, input word_t s1);
    word_t a;
    word_t b;
    b = s1 ^ (s1 << SHIFT_A);
    b = b ^ (b >> SHIFT_B);
    a = s0 ^ (s0 >> SHIFT_C);
    return a ^ b;
  endfunction

endpackage

`default_nettype wire

@@ src/xsr_in_if.sv @@
`default_nettype none

interface xsr_in_if;
  import xsr_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  pos_t  load_index;
  word_t load_value;

  modport source (output valid, output cmd, output load_index, output load_value,
                  input ready);
  modport sink   (input valid, input cmd, input load_index, input load_value,
                  output ready);
endinterface

`default_nettype wire

@@ src/xsr_out_if.sv @@
`default_nettype none

interface xsr_out_if;
  import xsr_pkg::*;

  logic  valid;
  logic  ready;
  half_t rand_word;
  logic  word_valid;

  modport source (output valid, output rand_word, output word_valid, input ready);
  modport sink   (input valid, input rand_word, input word_valid, output ready);
endinterface

`default_nettype wire

@@ src/xsr_state_ram.sv @@
`default_nettype none

module xsr_state_ram
  import xsr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire ram_wr_t wr,
  input  wire pos_t    rd_addr_a,
  input  wire pos_t    rd_addr_b,
  output word_t        rd_data_a,
  output word_t        rd_data_b
);

  word_t            mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  word_t            rd_a_r;
  word_t            rd_b_r;
  logic             rd_a_vld_r;
  logic             rd_b_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Written flags; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Two registered read ports, old data on a same-cycle write
  always_ff @(posedge clk) begin
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_a_vld_r <= 1'b0;
      rd_b_vld_r <= 1'b0;
    end else begin
      rd_a_vld_r <= vld_r[rd_addr_a];
      rd_b_vld_r <= vld_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_vld_r ? rd_a_r : '0;
  assign rd_data_b = rd_b_vld_r ? rd_b_r : '0;

endmodule

`default_nettype wire

@@ src/xsr_out_pipe.sv @@
`default_nettype none

module xsr_out_pipe
  import xsr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   item_valid,
  input  wire item_t  item,
  output logic        item_ready,
  xsr_out_if.source   out_if
);

  // Stage A: step result waiting for the multipliers
  logic  a_v_r;
  kind_t a_kind_r;
  word_t a_word_r;
  // Stage B: partial products
  logic  b_v_r;
  kind_t b_kind_r;
  word_t p_ll_r;
  half_t p_lh_r;
  half_t p_hl_r;
  // Stage C: output register
  logic  out_v_r;
  half_t out_word_r;
  logic  out_wv_r;
  // Cached upper half of the last product
  half_t hi_r;

  logic  c_ready;
  logic  b_ready;
  logic  b_move;
  logic  a_move;
  word_t p_ll;
  half_t p_lh;
  half_t p_hl;
  half_t mid_sum;
  word_t prod;
  half_t word_nxt;
  logic  wv_nxt;

  // Stage handshakes: a stage fills when it is empty or moves on
  assign c_ready    = !out_v_r || out_if.ready;
  assign b_move     = b_v_r && c_ready;
  assign b_ready    = !b_v_r || c_ready;
  assign a_move     = a_v_r && b_ready;
  assign item_ready = !a_v_r || b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (item_ready) begin
        a_v_r <= item_valid;
      end
      if (b_ready) begin
        b_v_r <= a_v_r;
      end
      if (c_ready) begin
        out_v_r <= b_v_r;
      end
    end
  end

  // Stage A capture
  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      a_kind_r <= item.kind;
      a_word_r <= item.word;
    end
  end

  // 32x32 partial products; only the low 32 bits of the cross terms matter mod 2^64
  assign p_ll = word_t'(a_word_r[HALF_W-1:0]) * word_t'(MULT_LO);
  assign p_lh = a_word_r[HALF_W-1:0] * MULT_HI;
  assign p_hl = a_word_r[WORD_W-1:HALF_W] * MULT_LO;

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_kind_r <= a_kind_r;
      p_ll_r   <= p_ll;
      p_lh_r   <= p_lh;
      p_hl_r   <= p_hl;
    end
  end

  // Final sum and word select
  assign mid_sum = p_lh_r + p_hl_r;
  assign prod    = p_ll_r + {mid_sum, {HALF_W{1'b0}}};

  always_comb begin
    word_nxt = '0;
    wv_nxt   = 1'b0;
    unique case (b_kind_r)
      KIND_ADV: begin
        word_nxt = prod[HALF_W-1:0];
        wv_nxt   = 1'b1;
      end
      KIND_HIT: begin
        word_nxt = hi_r;
        wv_nxt   = 1'b1;
      end
      default: begin
        word_nxt = '0;
        wv_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      out_word_r <= word_nxt;
      out_wv_r   <= wv_nxt;
      if (b_kind_r == KIND_ADV) begin
        hi_r <= prod[WORD_W-1:HALF_W];
      end
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.rand_word  = out_word_r;
  assign out_if.word_valid = out_wv_r;

endmodule

`default_nettype wire

@@ src/xorshift1024_star_prng.sv @@
`default_nettype none

// Channel  Dir  Payload                                  Handshake
// in_if    in   cmd, load_index[3:0], load_value[63:0]   valid/ready
// out_if   out  rand_word[31:0], word_valid              valid/ready
//
// One word is accepted per cycle while the result pipe has room; each gives one result.
// The sixteen state words sit in a two-read-port RAM; the word at the position and
// the next one are kept in registers, the one after is prefetched on each step.
// Reset is synchronous; the state reads as zero until loaded.
// Output stalls fill the three-stage result pipe before the input is held off.

module xorshift1024_star_prng
  import xsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  xsr_in_if.sink    in_if,
  xsr_out_if.source out_if
);

  logic    accept;
  logic    is_load;
  logic    adv;
  logic    item_ready;
  item_t   item;
  ram_wr_t wr;
  pos_t    rd_addr_a;
  pos_t    rd_addr_b;
  word_t   rd_data_a;
  word_t   rd_data_b;

  pos_t    pos_r,      pos_nxt;
  logic    cached_r,   cached_nxt;
  word_t   cur_r,      cur_nxt;
  word_t   nxt_r,      nxt_nxt;
  logic    cur_pend_r, cur_pend_nxt;
  logic    nxt_pend_r, nxt_pend_nxt;
  logic    fwd_a_r,    fwd_a_nxt;
  logic    fwd_b_r,    fwd_b_nxt;
  word_t   fwd_val_r,  fwd_val_nxt;

  word_t   cur_eff;
  word_t   nxt_eff;
  word_t   new_word;

  assign in_if.ready = item_ready;
  assign accept      = in_if.valid && item_ready;
  assign is_load     = (in_if.cmd == CMD_LOAD);
  assign adv         = accept && !is_load && !cached_r;

  // Current pair, taken from read data (with load forwarding) while a fetch is due
  assign cur_eff  = cur_pend_r ? (fwd_a_r ? fwd_val_r : rd_data_a) : cur_r;
  assign nxt_eff  = nxt_pend_r ? (fwd_b_r ? fwd_val_r : rd_data_b) : nxt_r;
  assign new_word = xsr_next(cur_eff, nxt_eff);

  // Memory requests
  always_comb begin
    wr.en     = 1'b0;
    wr.addr   = pos_r + pos_t'(1);
    wr.data   = new_word;
    rd_addr_a = '0;
    rd_addr_b = pos_r + pos_t'(2);
    if (accept && is_load) begin
      wr.en     = 1'b1;
      wr.addr   = in_if.load_index;
      wr.data   = in_if.load_value;
      rd_addr_b = pos_t'(1);
    end else if (adv) begin
      wr.en = 1'b1;
    end
  end

  // Position, cache flag and the register pair
  always_comb begin
    pos_nxt      = pos_r;
    cached_nxt   = cached_r;
    cur_nxt      = cur_eff;
    nxt_nxt      = nxt_eff;
    cur_pend_nxt = 1'b0;
    nxt_pend_nxt = 1'b0;
    fwd_a_nxt    = 1'b0;
    fwd_b_nxt    = 1'b0;
    fwd_val_nxt  = fwd_val_r;
    if (accept && is_load) begin
      pos_nxt      = '0;
      cached_nxt   = 1'b0;
      cur_pend_nxt = 1'b1;
      nxt_pend_nxt = 1'b1;
      fwd_a_nxt    = (in_if.load_index == pos_t'(0));
      fwd_b_nxt    = (in_if.load_index == pos_t'(1));
      fwd_val_nxt  = in_if.load_value;
    end else if (adv) begin
      pos_nxt      = pos_r + pos_t'(1);
      cached_nxt   = 1'b1;
      cur_nxt      = new_word;
      nxt_pend_nxt = 1'b1;
    end else if (accept) begin
      cached_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      cached_r   <= 1'b0;
      cur_r      <= '0;
      nxt_r      <= '0;
      cur_pend_r <= 1'b0;
      nxt_pend_r <= 1'b0;
      fwd_a_r    <= 1'b0;
      fwd_b_r    <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      cached_r   <= cached_nxt;
      cur_r      <= cur_nxt;
      nxt_r      <= nxt_nxt;
      cur_pend_r <= cur_pend_nxt;
      nxt_pend_r <= nxt_pend_nxt;
      fwd_a_r    <= fwd_a_nxt;
      fwd_b_r    <= fwd_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_val_r <= fwd_val_nxt;
  end

  // Word handed to the result pipe
  always_comb begin
    item.word = new_word;
    if (is_load) begin
      item.kind = KIND_LOAD;
    end else if (cached_r) begin
      item.kind = KIND_HIT;
    end else begin
      item.kind = KIND_ADV;
    end
  end

  xsr_state_ram u_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  xsr_out_pipe u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_if.valid),
    .item       (item),
    .item_ready (item_ready),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire

@@ sim/tb_xorshift1024_star_prng.sv @@
`default_nettype none

module tb_xorshift1024_star_prng;
  import xsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  // One result word as the output channel carries it
  typedef struct {
    half_t rand_word;
    logic  word_valid;
  } rand_result_t;

  logic clk;
  logic rst_n;

  xsr_in_if  in_ch ();
  xsr_out_if out_ch ();

  xorshift1024_star_prng uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Generator model state
  word_t gen_state [DEPTH];
  pos_t  gen_pos;
  logic  half_held;
  half_t held_half;

  rand_result_t pending_words [$];

  int src_gap_pct;
  int sink_stall_pct;
  int mismatches    = 0;
  int cycles        = 0;
  int gens_checked  = 0;
  int loads_checked = 0;

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles,
               pending_words.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Advance the xorshift1024 recurrence once and return the multiplied word
  function automatic word_t advance_gen();
    word_t s0;
    word_t s1;
    word_t mixed;
    s0 = gen_state[gen_pos];
    gen_pos = gen_pos + pos_t'(1);
    s1 = gen_state[gen_pos];
    s1 = s1 ^ (s1 << SHIFT_A);
    s1 = s1 ^ (s1 >> SHIFT_B);
    s0 = s0 ^ (s0 >> SHIFT_C);
    mixed = s0 ^ s1;
    gen_state[gen_pos] = mixed;
    return mixed * MULT_CONST;
  endfunction

  // Expected result of one accepted input word; updates the model state
  function automatic rand_result_t predict_rand_word(input logic c, input pos_t idx,
                                                     input word_t val);
    rand_result_t r;
    word_t        prod;
    if (c == CMD_LOAD) begin
      gen_state[idx] = val;
      gen_pos        = '0;
      half_held      = 1'b0;
      held_half      = '0;
      r.rand_word    = '0;
      r.word_valid   = 1'b0;
    end else if (half_held) begin
      r.rand_word  = held_half;
      r.word_valid = 1'b1;
      half_held    = 1'b0;
      held_half    = '0;
    end else begin
      prod         = advance_gen();
      r.rand_word  = prod[HALF_W-1:0];
      r.word_valid = 1'b1;
      held_half    = prod[WORD_W-1:HALF_W];
      half_held    = 1'b1;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Monitor: check the output word first, then queue the prediction for the input word
  always @(posedge clk) begin : word_monitor
    rand_result_t want;
    if (!rst_n) begin
      foreach (gen_state[i]) gen_state[i] = '0;
      gen_pos   = '0;
      half_held = 1'b0;
      held_half = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_words.size() == 0) begin
          note_mismatch("unexpected word", '0, {31'd0, out_ch.word_valid, out_ch.rand_word});
        end else begin
          want = pending_words.pop_front();
          if (out_ch.rand_word !== want.rand_word)
            note_mismatch("rand_word", 64'(want.rand_word), 64'(out_ch.rand_word));
          if (out_ch.word_valid !== want.word_valid)
            note_mismatch("word_valid", 64'(want.word_valid), 64'(out_ch.word_valid));
          if (want.word_valid) gens_checked++;
          else loads_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_words.push_back(predict_rand_word(in_ch.cmd, in_ch.load_index,
                                                  in_ch.load_value));
    end
  end

  // Send one word; called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic c, input pos_t idx, input word_t val);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.load_index <= idx;
    in_ch.load_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic word_t rand_state_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(WORD_W-1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // All-zero state after reset keeps yielding zero; load fields ignored on generate
  task automatic test_zero_state();
    send_word(CMD_GEN, '0, '0);
    send_word(CMD_GEN, '1, '1);
    send_word(CMD_GEN, '1, '1);
  endtask

  // Loads at the index extremes with extreme values, then generate from position zero
  task automatic test_load_extremes();
    send_word(CMD_LOAD, 4'd0, '1);
    send_word(CMD_LOAD, 4'd15, 64'h8000_0000_0000_0001);
    send_word(CMD_LOAD, 4'd1, '0);
    send_word(CMD_GEN, 4'd9, 64'hDEAD_BEEF_0123_4567);
    send_word(CMD_GEN, '0, '0);
    send_word(CMD_GEN, '1, '1);
    send_word(CMD_GEN, '0, '0);
  endtask

  // A load while a high half is held drops it and restarts at position zero
  task automatic test_cache_and_reload();
    send_word(CMD_GEN, '0, '0);
    send_word(CMD_LOAD, 4'd7, 64'h5555_5555_AAAA_AAAA);
    send_word(CMD_GEN, '0, '0);
    send_word(CMD_GEN, '0, '0);
    send_word(CMD_LOAD, 4'd1, '1);
    send_word(CMD_LOAD, 4'd0, '0);
    send_word(CMD_GEN, '0, '0);
    send_word(CMD_GEN, '0, '0);
    send_word(CMD_GEN, '0, '0);
  endtask

  // Mostly reseed-then-generate runs with random content; some noise words in between
  task automatic test_random_streams(input int n_items);
    int sent;
    int k;
    int first;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        k     = ($urandom_range(3) == 0) ? $urandom_range(1, DEPTH-1) : DEPTH;
        first = $urandom_range(DEPTH-1);
        for (int i = 0; i < k; i++) begin
          send_word(CMD_LOAD, pos_t'(first + i), rand_state_word());
          sent++;
        end
        k = ($urandom_range(9) == 0) ? $urandom_range(100, 200) : $urandom_range(4, 48);
        repeat (k) begin
          send_word(CMD_GEN, pos_t'($urandom), {$urandom, $urandom});
          sent++;
        end
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          send_word(logic'($urandom_range(1)), pos_t'($urandom), rand_state_word());
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_GEN;
    in_ch.load_index = '0;
    in_ch.load_value = '0;
    src_gap_pct      = 16;
    sink_stall_pct   = 51;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_zero_state();
    test_load_extremes();
    test_cache_and_reload();
    test_random_streams(530);

    src_gap_pct    = 51;
    sink_stall_pct = 16;
    test_random_streams(550);

    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_random_streams(550);

    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d generated words and %0d loads across three idling patterns,",
             gens_checked, loads_checked);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
